// ----- hdl/lcrs_pkg.sv -----
// Shared constants, neighbour step tables and the dimension clamp for the
// largest connected region block. No dependencies.
`default_nettype none
package lcrs_pkg;
	localparam int DIM_W        = 7;
	localparam int SIZE_W       = 13;
	localparam int SIZE_MAX     = 8191;
	localparam int CMP_W        = 11;
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;
	localparam int FIFO_DEPTH   = 2;
	localparam int NB_COUNT     = 8;

	localparam logic [1:0] STEP_NEG  = 2'b11;
	localparam logic [1:0] STEP_ZERO = 2'b00;
	localparam logic [1:0] STEP_POS  = 2'b01;

	localparam logic [1:0] STEP_ROW [NB_COUNT] = '{STEP_NEG, STEP_NEG, STEP_NEG,
		STEP_ZERO, STEP_ZERO, STEP_POS, STEP_POS, STEP_POS};
	localparam logic [1:0] STEP_COL [NB_COUNT] = '{STEP_ZERO, STEP_NEG, STEP_POS,
		STEP_NEG, STEP_POS, STEP_ZERO, STEP_NEG, STEP_POS};

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// Zero counts as one, anything above the limit counts as the limit.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input int unsigned lim);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (CMP_W'(v) > CMP_W'(lim)) begin
			r = DIM_W'(lim);
		end else begin
			r = v;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- hdl/lcrs_front.sv -----
// Front end: holds the dimension registers, counts pixel beats and turns each
// into a store command for the back end. Depends on lcrs_pkg.
`default_nettype none
module lcrs_front import lcrs_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int RW = 6,
	parameter int CW = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_addr,
	input  wire logic [DIM_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic              pixel,
	output logic [DIM_W-1:0]       rows,
	output logic [DIM_W-1:0]       cols,
	output logic                   cmd_push,
	output logic [RW+CW+1:0]       cmd_data
);
	logic [DIM_W-1:0] rows_q, cols_q;
	logic [RW-1:0]    r_q;
	logic [CW-1:0]    c_q;
	logic             last_c, last_r;

	assign rows     = rows_q;
	assign cols     = cols_q;
	assign last_c   = CMP_W'(c_q) == CMP_W'(cols_q - DIM_W'(1));
	assign last_r   = CMP_W'(r_q) == CMP_W'(rows_q - DIM_W'(1));
	assign cmd_push = in_valid && !in_stall;
	assign cmd_data = {r_q, c_q, pixel, last_r && last_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= clamp_dim(DIM_W'(64), MAX_ROWS);
			cols_q <= clamp_dim(DIM_W'(64), MAX_COLS);
			r_q    <= '0;
			c_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_addr == CFG_ROWS) begin
				rows_q <= clamp_dim(cfg_data, MAX_ROWS);
			end else begin
				cols_q <= clamp_dim(cfg_data, MAX_COLS);
			end
			r_q <= '0;
			c_q <= '0;
		end else if (cmd_push) begin
			if (last_c) begin
				c_q <= '0;
				r_q <= last_r ? '0 : r_q + RW'(1);
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/lcrs_fifo.sv -----
// Short command queue between the front and back ends.
// Depends on lcrs_pkg for its depth.
`default_nettype none
module lcrs_fifo import lcrs_pkg::*; #(
	parameter int W = 14
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              full,
	output logic              empty
);
	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	logic [W-1:0] slot_q [FIFO_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full  = cnt_q == (PW+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(FIFO_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(FIFO_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ----- hdl/lcrs_back.sv -----
// Back end: image store, visited map and breadth-first queue memories with the
// sequencer that scans the image, floods regions and keeps the largest size.
// Depends on lcrs_pkg.
`default_nettype none
module lcrs_back import lcrs_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int RW = 6,
	parameter int CW = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [DIM_W-1:0] rows,
	input  wire logic [DIM_W-1:0] cols,
	input  wire logic             cmd_empty,
	input  wire logic [RW+CW+1:0] cmd_data,
	output logic                  cmd_pop,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output logic [SIZE_W-1:0]     largest_size,
	output logic                  found
);
	localparam int AW    = RW + CW;
	localparam int CELLS = 2 ** AW;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_SCAN_CHK = 3'd2;
	localparam logic [2:0] S_POP      = 3'd3;
	localparam logic [2:0] S_POP_W    = 3'd4;
	localparam logic [2:0] S_NB       = 3'd5;
	localparam logic [2:0] S_NB_CHK   = 3'd6;
	localparam logic [2:0] S_OUT      = 3'd7;

	logic          img_mem [CELLS];
	logic          vis_mem [CELLS];
	logic [AW-1:0] q_mem   [CELLS];

	logic [2:0]        state_q;
	logic [RW-1:0]     scan_r_q, cur_r_q;
	logic [CW-1:0]     scan_c_q, cur_c_q;
	logic [AW:0]       head_q, tail_q;
	logic [2:0]        k_q;
	logic [AW-1:0]     nb_addr_q;
	logic [SIZE_W-1:0] cur_size_q, best_q;
	logic              img_rd_q, vis_rd_q;
	logic [AW-1:0]     q_rd_q;
	logic              out_valid_q, found_q;
	logic [SIZE_W-1:0] size_out_q;

	logic [AW-1:0] scan_addr, rd_addr, nb_addr, cmd_addr;
	logic          cmd_pix, cmd_last, scan_last;
	logic [1:0]    dr, dc;
	logic          nb_ok;
	logic [RW-1:0] nr;
	logic [CW-1:0] nc;
	logic          vis_we, vis_wd, q_we;
	logic [AW-1:0] vis_wa;

	assign cmd_addr  = cmd_data[AW+1:2];
	assign cmd_pix   = cmd_data[1];
	assign cmd_last  = cmd_data[0];
	assign cmd_pop   = (state_q == S_IDLE) && !cmd_empty;
	assign scan_addr = {scan_r_q, scan_c_q};
	assign scan_last = (CMP_W'(scan_r_q) == CMP_W'(rows - DIM_W'(1)))
		&& (CMP_W'(scan_c_q) == CMP_W'(cols - DIM_W'(1)));

	// Neighbour position and bounds for the current step.
	always_comb begin
		dr    = STEP_ROW[k_q];
		dc    = STEP_COL[k_q];
		nb_ok = 1'b1;
		nr    = cur_r_q;
		nc    = cur_c_q;
		if (dr == STEP_NEG) begin
			nb_ok = nb_ok && (cur_r_q != '0);
			nr    = cur_r_q - RW'(1);
		end else if (dr == STEP_POS) begin
			nb_ok = nb_ok && (CMP_W'(cur_r_q) + CMP_W'(1) < CMP_W'(rows));
			nr    = cur_r_q + RW'(1);
		end
		if (dc == STEP_NEG) begin
			nb_ok = nb_ok && (cur_c_q != '0);
			nc    = cur_c_q - CW'(1);
		end else if (dc == STEP_POS) begin
			nb_ok = nb_ok && (CMP_W'(cur_c_q) + CMP_W'(1) < CMP_W'(cols));
			nc    = cur_c_q + CW'(1);
		end
		nb_addr = {nr, nc};
	end

	assign rd_addr = (state_q == S_NB) ? nb_addr : scan_addr;

	always_comb begin
		vis_we = 1'b0;
		vis_wd = 1'b0;
		vis_wa = cmd_addr;
		q_we   = 1'b0;
		if (cmd_pop) begin
			vis_we = 1'b1;
		end else if (state_q == S_SCAN_CHK && img_rd_q && !vis_rd_q) begin
			vis_we = 1'b1;
			vis_wd = 1'b1;
			vis_wa = scan_addr;
			q_we   = 1'b1;
		end else if (state_q == S_NB_CHK && img_rd_q && !vis_rd_q) begin
			vis_we = 1'b1;
			vis_wd = 1'b1;
			vis_wa = nb_addr_q;
			q_we   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			img_mem[cmd_addr] <= cmd_pix;
		end
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		if (q_we) begin
			q_mem[tail_q[AW-1:0]] <= vis_wa;
		end
		img_rd_q <= img_mem[rd_addr];
		vis_rd_q <= vis_mem[rd_addr];
		q_rd_q   <= q_mem[head_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_r_q    <= '0;
			scan_c_q    <= '0;
			cur_r_q     <= '0;
			cur_c_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			k_q         <= '0;
			nb_addr_q   <= '0;
			cur_size_q  <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			size_out_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop && cmd_last) begin
						scan_r_q <= '0;
						scan_c_q <= '0;
						best_q   <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (img_rd_q && !vis_rd_q) begin
						// The queue is empty here, so the seed takes the slot at
						// the tail and the head moves up to meet it.
						head_q     <= tail_q;
						tail_q     <= tail_q + (AW+1)'(1);
						cur_size_q <= '0;
						state_q    <= S_POP;
					end else if (scan_last) begin
						state_q <= S_OUT;
					end else begin
						if (CMP_W'(scan_c_q) == CMP_W'(cols - DIM_W'(1))) begin
							scan_c_q <= '0;
							scan_r_q <= scan_r_q + RW'(1);
						end else begin
							scan_c_q <= scan_c_q + CW'(1);
						end
						state_q <= S_SCAN;
					end
				end
				S_POP: begin
					if (head_q != tail_q) begin
						head_q  <= head_q + (AW+1)'(1);
						state_q <= S_POP_W;
					end else begin
						if (cur_size_q > best_q) begin
							best_q <= cur_size_q;
						end
						if (scan_last) begin
							state_q <= S_OUT;
						end else begin
							if (CMP_W'(scan_c_q) == CMP_W'(cols - DIM_W'(1))) begin
								scan_c_q <= '0;
								scan_r_q <= scan_r_q + RW'(1);
							end else begin
								scan_c_q <= scan_c_q + CW'(1);
							end
							state_q <= S_SCAN;
						end
					end
				end
				S_POP_W: begin
					cur_r_q <= q_rd_q[AW-1:CW];
					cur_c_q <= q_rd_q[CW-1:0];
					if (cur_size_q != SIZE_W'(SIZE_MAX)) begin
						cur_size_q <= cur_size_q + SIZE_W'(1);
					end
					k_q     <= '0;
					state_q <= S_NB;
				end
				S_NB: begin
					if (nb_ok) begin
						nb_addr_q <= nb_addr;
						state_q   <= S_NB_CHK;
					end else if (k_q == 3'(NB_COUNT - 1)) begin
						state_q <= S_POP;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_NB_CHK: begin
					if (img_rd_q && !vis_rd_q) begin
						tail_q <= tail_q + (AW+1)'(1);
					end
					if (k_q == 3'(NB_COUNT - 1)) begin
						state_q <= S_POP;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= S_NB;
					end
				end
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						size_out_q  <= best_q;
						found_q     <= best_q != '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign largest_size = size_out_q;
	assign found        = found_q;
endmodule
`default_nettype wire

// ----- hdl/largest_connected_region_size_core.sv -----
// Top level of the largest connected region block: front end, command queue
// and flood-fill back end. Depends on lcrs_pkg, lcrs_front, lcrs_fifo, lcrs_back.
//
// Usage: pixels arrive one per beat on in_valid/in_stall, row-major, row_count
// rows by col_count columns (set through cfg_we/cfg_addr/cfg_data while idle;
// index 0 is the row count, 1 the column count; zero counts as one and values
// above the maximum are clamped). A dimension write restarts the image.
// Each pixel beat becomes a store command in a two-entry queue; while idle the
// back end drains it into the image store at one pixel per cycle, so loading
// runs at one beat per cycle until a busy back end lets the queue fill. After
// the last pixel of an image the back end scans every cell (S_SCAN and
// S_SCAN_CHK) and floods each new region breadth first: it takes a cell from
// the queue (S_POP, S_POP_W), then checks each of its 8 neighbours (S_NB,
// S_NB_CHK), as the image, visited and queue memories each give one
// registered read a cycle.
// The single result beat (largest_size, found) sits in an output register on
// out_valid/out_stall; a stalled result holds and the back end waits, while
// pixels of the next image keep entering until the command queue fills.
// The visited map is cleared entry by entry as pixels load, so no clearing
// pass is needed. Reset clears all control state and sets both dimensions
// to 64 (clamped to the maximum).
`default_nettype none
module largest_connected_region_size_core import lcrs_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_addr,
	input  wire logic [DIM_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              pixel,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [SIZE_W-1:0]      largest_size,
	output logic                   found
);
	localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CMD_W    = RW + CW + 2;
	localparam int SIZE_CAP = (MAX_ROWS * MAX_COLS > SIZE_MAX) ? SIZE_MAX
		: MAX_ROWS * MAX_COLS;

	logic [DIM_W-1:0] rows, cols;
	logic             cmd_push, cmd_pop, cmd_full, cmd_empty;
	logic [CMD_W-1:0] cmd_wdata, cmd_rdata;

	// The queue being full is the only reason to hold off a pixel beat.
	assign in_stall = cmd_full;

	lcrs_front #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .RW(RW), .CW(CW)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.rows(rows), .cols(cols),
		.cmd_push(cmd_push), .cmd_data(cmd_wdata)
	);

	lcrs_fifo #(.W(CMD_W)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(cmd_push), .wdata(cmd_wdata),
		.pop(cmd_pop), .rdata(cmd_rdata),
		.full(cmd_full), .empty(cmd_empty)
	);

	lcrs_back #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .RW(RW), .CW(CW)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.rows(rows), .cols(cols),
		.cmd_empty(cmd_empty), .cmd_data(cmd_rdata), .cmd_pop(cmd_pop),
		.out_stall(out_stall), .out_valid(out_valid),
		.largest_size(largest_size), .found(found)
	);

	// The found flag must agree with a non-zero size.
	a_found_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (found == (largest_size != '0)))
		else $error("found flag disagrees with largest_size");

	// No region can be larger than the image itself.
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (largest_size <= SIZE_W'(SIZE_CAP)))
		else $error("largest_size exceeds the image size");

	// Commands are only taken while the queue holds some.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command queue popped while empty");
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for largest_connected_region_size_core: streams binary
// images, predicts the largest 8-connected region and checks each result beat.
// Depends on lcrs_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
	import lcrs_pkg::*;

	localparam int GRID       = 64;
	localparam int IDLE_LIMIT = 40000;
	localparam int HOLD_LEN   = 400;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              flag;
	} region_result_t;

	// Scoreboard: keeps its own image store and dimension registers, floods
	// each completed image and queues the result that the block must give.
	class region_board;
		bit                img [GRID][GRID];
		logic [DIM_W-1:0]  rows_reg;
		logic [DIM_W-1:0]  cols_reg;
		int                pix_count;
		region_result_t    awaited [$];
		int                errors;

		function new();
			rows_reg  = DIM_W'(64);
			cols_reg  = DIM_W'(64);
			pix_count = 0;
			errors    = 0;
		endfunction

		function int eff_dim(logic [DIM_W-1:0] v);
			if (v == 0) return 1;
			return (v > GRID) ? GRID : int'(v);
		endfunction

		// A dimension write discards any partial image.
		function void set_dim(logic idx, logic [DIM_W-1:0] v);
			if (idx == CFG_ROWS) rows_reg = v;
			else cols_reg = v;
			pix_count = 0;
		endfunction

		function int largest_region(int nr, int nc);
			bit seen [GRID][GRID];
			int q [$];
			int best, cnt, pos, r, c, ar, ac;
			best = 0;
			for (int i = 0; i < nr; i++)
				for (int j = 0; j < nc; j++)
					seen[i][j] = 0;
			for (int i = 0; i < nr; i++) begin
				for (int j = 0; j < nc; j++) begin
					if (seen[i][j] || !img[i][j]) continue;
					seen[i][j] = 1;
					q.push_back(i * GRID + j);
					cnt = 0;
					while (q.size() > 0) begin
						pos = q.pop_front();
						r = pos / GRID;
						c = pos % GRID;
						cnt++;
						for (int dr = -1; dr <= 1; dr++) begin
							for (int dc = -1; dc <= 1; dc++) begin
								ar = r + dr;
								ac = c + dc;
								if ((dr == 0 && dc == 0) || ar < 0 || ac < 0 ||
									ar >= nr || ac >= nc) continue;
								if (!seen[ar][ac] && img[ar][ac]) begin
									seen[ar][ac] = 1;
									q.push_back(ar * GRID + ac);
								end
							end
						end
					end
					if (cnt > best) best = cnt;
				end
			end
			return best;
		endfunction

		function void note_pixel(logic p);
			int nr, nc, best;
			region_result_t res;
			nr = eff_dim(rows_reg);
			nc = eff_dim(cols_reg);
			if (pix_count >= nr * nc) pix_count = 0;
			img[pix_count / nc][pix_count % nc] = p;
			pix_count++;
			if (pix_count < nr * nc) return;
			pix_count = 0;
			best = largest_region(nr, nc);
			if (best > SIZE_MAX) best = SIZE_MAX;
			res.size = SIZE_W'(best);
			res.flag = (best > 0);
			awaited.push_back(res);
		endfunction

		function void check_result(logic [SIZE_W-1:0] size, logic flag);
			region_result_t want;
			if (awaited.size() == 0) begin
				$error("result beat with nothing awaited: largest_size %0d found %0b",
					size, flag);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (size !== want.size) begin
				$error("largest_size: expected %0d, actual %0d", want.size, size);
				errors++;
			end
			if (flag !== want.flag) begin
				$error("found: expected %0b, actual %0b", want.flag, flag);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_addr = 1'b0;
	logic [DIM_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              pixel = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [SIZE_W-1:0] largest_size;
	logic              found;

	region_board board = new();

	// Idling is switched off for the closing stretch of the run.
	bit quiet    = 1'b0;
	bit hold_req = 1'b0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	largest_connected_region_size_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.largest_size (largest_size),
		.found        (found)
	);

	// Result side: every accepted beat is checked at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(largest_size, found);
	end

	// Receiver stall: short random bursts, plus one long hold-off on request so
	// the result register stays full and the block has to stall its input.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offers one pixel beat and returns on the edge that accepts it; the
	// caller is left just after that rising edge.
	task automatic send_pixel(input logic p);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= p;
		do @(posedge clk); while (in_stall);
		board.note_pixel(p);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Waits for every awaited result, then lets the back end settle.
	task automatic drain();
		drop_valid();
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_dim(input logic idx, input logic [DIM_W-1:0] v);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v;
		@(posedge clk);
		board.set_dim(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_shape(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
		drain();
		write_dim(CFG_ROWS, r);
		write_dim(CFG_COLS, c);
	endtask

	// One whole image with the given percentage of set pixels.
	task automatic send_image(input int density);
		int n;
		n = board.eff_dim(board.rows_reg) * board.eff_dim(board.cols_reg);
		for (int i = 0; i < n; i++)
			send_pixel($urandom_range(0, 99) < density);
	endtask

	// Random images of the current shape until the beat budget is used up;
	// the density is picked per image so both sparse and dense fills occur.
	task automatic random_images(input int budget);
		int sent, n, d;
		sent = 0;
		n = board.eff_dim(board.rows_reg) * board.eff_dim(board.cols_reg);
		while (sent < budget) begin
			case ($urandom_range(0, 4))
				0: d = 0;
				1: d = 15;
				2: d = 45;
				3: d = 75;
				default: d = 100;
			endcase
			if ($urandom_range(0, 19) == 0) begin
				// A broken image: one to n random pixels, then a restart by dimension write.
				repeat ($urandom_range(1, n)) send_pixel($urandom_range(0, 1));
				drain();
				write_dim(CFG_COLS, board.cols_reg);
			end else begin
				send_image(d);
			end
			sent += n;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: single-pixel images, clear and set.
		set_shape(DIM_W'(1), DIM_W'(1));
		send_pixel(1'b0);
		send_pixel(1'b1);
		// Zero and the top code clamp to one row and sixty-four columns.
		set_shape(DIM_W'(0), DIM_W'(127));
		for (int i = 0; i < GRID; i++) send_pixel(i % 3 != 1);
		// Three by three: a diagonal chain joins only through corners.
		set_shape(DIM_W'(3), DIM_W'(3));
		for (int i = 0; i < 9; i++) send_pixel(i == 0 || i == 4 || i == 8);
		send_image(100);
		// A partial image thrown away by a dimension write.
		send_pixel(1'b1);
		send_pixel(1'b1);
		drain();
		write_dim(CFG_ROWS, DIM_W'(3));
		send_image(0);

		set_shape(DIM_W'(5), DIM_W'(7));
		random_images(300);
		set_shape(DIM_W'(64), DIM_W'(1));
		random_images(256);
		set_shape(DIM_W'(2), DIM_W'(64));
		random_images(256);

		// Long receiver hold-off while small images keep streaming in.
		set_shape(DIM_W'(2), DIM_W'(2));
		hold_req = 1'b1;
		random_images(200);

		set_shape(DIM_W'(8), DIM_W'(8));
		random_images(260);

		set_shape(DIM_W'(3), DIM_W'(5));
		quiet = 1'b1;
		random_images(200);

		drain();
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
